// ----- src/dwpid_pkg.sv -----
// Shared types and constants for the dual-wheel incremental PID core.
// Holds the datapath step codes, register indexes and the speed map table.
// No dependencies.
package dwpid_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_KP        = 3'd0;
  localparam logic [2:0] REG_KI        = 3'd1;
  localparam logic [2:0] REG_KD        = 3'd2;
  localparam logic [2:0] REG_LSCALE    = 3'd3;
  localparam logic [2:0] REG_RSCALE    = 3'd4;
  localparam logic [2:0] REG_MIN_DRIVE = 3'd5;
  localparam logic [2:0] REG_MAX_DRIVE = 3'd6;

  // Reset values of the registers
  localparam logic [31:0] KP_RST        = 32'd83886;
  localparam logic [31:0] KI_RST        = 32'd403;
  localparam logic [31:0] KD_RST        = -32'sd25166;
  localparam logic [17:0] LSCALE_RST    = 18'd69148;
  localparam logic [17:0] RSCALE_RST    = 18'd69473;
  localparam logic [9:0]  MIN_DRIVE_RST = 10'd100;
  localparam logic [9:0]  MAX_DRIVE_RST = 10'd1000;

  // Datapath step codes
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_ROM  = 4'd1;  // fetch exp entry
  localparam logic [3:0] OP_MSPD = 4'd2;  // scale * exp
  localparam logic [3:0] OP_ERR  = 4'd3;  // round speed, form error
  localparam logic [3:0] OP_MKP  = 4'd4;  // kp * e
  localparam logic [3:0] OP_MKI  = 4'd5;  // ki * e, acc = kp term
  localparam logic [3:0] OP_MKD  = 4'd6;  // kd * de, acc += ki term
  localparam logic [3:0] OP_ACC  = 4'd7;  // acc += kd term
  localparam logic [3:0] OP_DRV  = 4'd8;  // round, add, clamp, store

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture input beat
    logic       side;      // 0 left, 1 right
    logic [3:0] op;
    logic       out_load;  // move drives into the output register
  } dwpid_cmd_t;

  // exp(0.0065 * c) table, unsigned Q.24
  localparam int EXP_W     = 27;
  localparam int EXP_DEPTH = 256;
  localparam logic [63:0] EXP_STEP = 64'd28008216;

  typedef logic [EXP_DEPTH-1:0][EXP_W-1:0] exp_rom_t;

  function automatic exp_rom_t exp_rom_build();
    exp_rom_t    rom;
    logic [63:0] e;
    int          c;
    e = 64'd1 << 24;
    for (c = 0; c < EXP_DEPTH; c++) begin
      rom[c] = e[EXP_W-1:0];
      e = e + ((e * EXP_STEP + (64'd1 << 31)) >> 32);
    end
    return rom;
  endfunction

endpackage

// ----- src/dwpid_ctrl.sv -----
// Sequencer of the dual-wheel PID core: steps the datapath through both wheels
// and owns the input/output handshakes. Depends on dwpid_pkg.
module dwpid_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dwpid_pkg::dwpid_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ROM  = 4'd1;
  localparam logic [3:0] ST_MSPD = 4'd2;
  localparam logic [3:0] ST_ERR  = 4'd3;
  localparam logic [3:0] ST_MKP  = 4'd4;
  localparam logic [3:0] ST_MKI  = 4'd5;
  localparam logic [3:0] ST_MKD  = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_DRV  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0] state, state_next;
  logic       side, side_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    side_next  = side;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ROM;
          side_next  = 1'b0;
        end
      end
      ST_ROM:  state_next = ST_MSPD;
      ST_MSPD: state_next = ST_ERR;
      ST_ERR:  state_next = ST_MKP;
      ST_MKP:  state_next = ST_MKI;
      ST_MKI:  state_next = ST_MKD;
      ST_MKD:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_DRV;
      ST_DRV: begin
        if (side == 1'b0) begin
          state_next = ST_ROM;
          side_next  = 1'b1;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.side     = side;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.out_load = (state == ST_OUT) && out_free;
    case (state)
      ST_ROM:  cmd.op = dwpid_pkg::OP_ROM;
      ST_MSPD: cmd.op = dwpid_pkg::OP_MSPD;
      ST_ERR:  cmd.op = dwpid_pkg::OP_ERR;
      ST_MKP:  cmd.op = dwpid_pkg::OP_MKP;
      ST_MKI:  cmd.op = dwpid_pkg::OP_MKI;
      ST_MKD:  cmd.op = dwpid_pkg::OP_MKD;
      ST_ACC:  cmd.op = dwpid_pkg::OP_ACC;
      ST_DRV:  cmd.op = dwpid_pkg::OP_DRV;
      default: cmd.op = dwpid_pkg::OP_NOP;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      side      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- src/dwpid_datapath.sv -----
// Datapath of the dual-wheel PID core: configuration registers, speed table,
// one shared multiplier, accumulator, clamp and wheel state. Depends on dwpid_pkg.
module dwpid_datapath #(
  parameter int COUNT_MAX = 200
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dwpid_pkg::dwpid_cmd_t cmd,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [9:0]            left_target,
  input  logic [9:0]            right_target,
  input  logic [7:0]            left_count,
  input  logic [7:0]            right_count,
  output logic [9:0]            left_drive,
  output logic [9:0]            right_drive
);

  localparam int CNT_LIM = (COUNT_MAX > 255) ? 255 : COUNT_MAX;
  localparam logic [7:0] CNT_LIM_V = CNT_LIM[7:0];
  localparam dwpid_pkg::exp_rom_t EXP_ROM = dwpid_pkg::exp_rom_build();

  // configuration
  logic signed [31:0] kp, ki, kd;
  logic [17:0]        scale [2];
  logic [9:0]         min_drive, max_drive;

  // captured beat and wheel state
  logic [9:0]         tgt_r   [2];
  logic [7:0]         cnt_r   [2];
  logic signed [19:0] prev_err [2];
  logic [17:0]        prev_drive [2];

  // working registers
  logic [dwpid_pkg::EXP_W-1:0] exp_q;
  logic signed [59:0]          prod;
  logic signed [53:0]          acc;
  logic signed [19:0]          err_q;

  logic               side;
  logic [7:0]         cnt_sel, idx;
  logic signed [31:0] mul_a;
  logic signed [27:0] mul_b;
  logic [45:0]        spd_sum;
  logic [21:0]        speed;
  logic signed [22:0] diff;
  logic signed [19:0] err_sat;
  logic signed [20:0] derr;
  logic signed [53:0] rnd;
  logic signed [29:0] inc;
  logic signed [30:0] d_raw, d_lo, d_fin, lo_lim, hi_lim;

  assign side = cmd.side;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp        <= dwpid_pkg::KP_RST;
      ki        <= dwpid_pkg::KI_RST;
      kd        <= dwpid_pkg::KD_RST;
      scale[0]  <= dwpid_pkg::LSCALE_RST;
      scale[1]  <= dwpid_pkg::RSCALE_RST;
      min_drive <= dwpid_pkg::MIN_DRIVE_RST;
      max_drive <= dwpid_pkg::MAX_DRIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dwpid_pkg::REG_KP:        kp        <= cfg_data;
        dwpid_pkg::REG_KI:        ki        <= cfg_data;
        dwpid_pkg::REG_KD:        kd        <= cfg_data;
        dwpid_pkg::REG_LSCALE:    scale[0]  <= cfg_data[17:0];
        dwpid_pkg::REG_RSCALE:    scale[1]  <= cfg_data[17:0];
        dwpid_pkg::REG_MIN_DRIVE: min_drive <= cfg_data[9:0];
        dwpid_pkg::REG_MAX_DRIVE: max_drive <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // table index, count saturated to COUNT_MAX (at most 255)
  assign cnt_sel = cnt_r[side];
  assign idx     = (cnt_sel > CNT_LIM_V) ? CNT_LIM_V : cnt_sel;

  // speed rounding and error saturation
  assign spd_sum = prod[45:0] + 46'd8388608;
  assign speed   = spd_sum[45:24];
  assign diff    = $signed({5'b0, tgt_r[side], 8'b0}) - $signed({1'b0, speed});
  always_comb begin
    if (diff > 23'sd524287)       err_sat = 20'sd524287;
    else if (diff < -23'sd524288) err_sat = -20'sd524288;
    else                          err_sat = diff[19:0];
  end

  assign derr = {err_q[19], err_q} - {prev_err[side][19], prev_err[side]};

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      dwpid_pkg::OP_MSPD: begin
        mul_a = $signed({14'b0, scale[side]});
        mul_b = $signed({1'b0, exp_q});
      end
      dwpid_pkg::OP_MKP: begin
        mul_a = kp;
        mul_b = {{8{err_q[19]}}, err_q};
      end
      dwpid_pkg::OP_MKI: begin
        mul_a = ki;
        mul_b = {{8{err_q[19]}}, err_q};
      end
      dwpid_pkg::OP_MKD: begin
        mul_a = kd;
        mul_b = {{7{derr[20]}}, derr};
      end
      default: begin
        mul_a = kp;
        mul_b = {{8{err_q[19]}}, err_q};
      end
    endcase
  end

  // increment rounding, new drive and clamps (lower first, upper last)
  assign rnd    = acc + 54'sd8388608;
  assign inc    = rnd[53:24];
  assign d_raw  = $signed({13'b0, prev_drive[side]}) + {inc[29], inc};
  assign lo_lim = $signed({13'b0, min_drive, 8'b0});
  assign hi_lim = $signed({13'b0, max_drive, 8'b0});
  assign d_lo   = (d_raw < lo_lim) ? lo_lim : d_raw;
  assign d_fin  = (d_lo > hi_lim) ? hi_lim : d_lo;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r[0] <= left_target;
      tgt_r[1] <= right_target;
      cnt_r[0] <= left_count;
      cnt_r[1] <= right_count;
    end
    case (cmd.op)
      dwpid_pkg::OP_ROM:  exp_q <= EXP_ROM[idx];
      dwpid_pkg::OP_MSPD: prod  <= mul_a * mul_b;
      dwpid_pkg::OP_ERR:  err_q <= err_sat;
      dwpid_pkg::OP_MKP:  prod  <= mul_a * mul_b;
      dwpid_pkg::OP_MKI: begin
        acc  <= prod[53:0];
        prod <= mul_a * mul_b;
      end
      dwpid_pkg::OP_MKD: begin
        acc  <= acc + prod[53:0];
        prod <= mul_a * mul_b;
      end
      dwpid_pkg::OP_ACC:  acc <= acc + prod[53:0];
      default: ;
    endcase
    if (cmd.out_load) begin
      left_drive  <= prev_drive[0][17:8];
      right_drive <= prev_drive[1][17:8];
    end
  end

  // wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err[0]   <= '0;
      prev_err[1]   <= '0;
      prev_drive[0] <= '0;
      prev_drive[1] <= '0;
    end else if (cmd.op == dwpid_pkg::OP_DRV) begin
      prev_err[side]   <= err_q;
      prev_drive[side] <= d_fin[17:0];
    end
  end

endmodule

// ----- src/dual_wheel_incremental_pid_core.sv -----
// Dual-wheel incremental PID speed controller, one drive pair per input beat.
// Each wheel takes eight steps through the single shared 32x28 multiplier, then the
// output state loads the result once the output register is free.
// A new beat is not taken until the sequence is through; one is taken while a result waits.
// Reset (rst, synchronous): gains, scales and limits to defaults, wheel state zero.
module dual_wheel_incremental_pid_core #(
  parameter int COUNT_MAX = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  left_target,
  input  logic [9:0]  right_target,
  input  logic [7:0]  left_count,
  input  logic [7:0]  right_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  left_drive,
  output logic [9:0]  right_drive,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dwpid_pkg::dwpid_cmd_t cmd;

  // sequencer
  dwpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and state
  dwpid_datapath #(
    .COUNT_MAX (COUNT_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_target  (left_target),
    .right_target (right_target),
    .left_count   (left_count),
    .right_count  (right_count),
    .left_drive   (left_drive),
    .right_drive  (right_drive)
  );

`ifndef SYNTHESIS
  // a taken beat starts the sequence, so no second beat follows at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // a result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while sequence still running");

  // a sequence never ends in the cycle right after a beat is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised straight after input");
`endif

endmodule
